// File: hw/rtl/mpem_pkg.sv
// Shared types, codes and defaults for the multi-pattern expect matcher.
// Depends on nothing; every file of the block but mpem_if.sv refers to it by scoped names.
package mpem_pkg;

    // Defaults for the top-level parameters.
    localparam int PATTERN_SLOTS_DEF   = 4;
    localparam int MAX_PATTERN_LEN_DEF = 8;

    // Number of pattern registers in the register map.
    localparam int REG_PATTERNS = 4;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Field widths.
    localparam int LEN_W   = 4;
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 3;
    localparam int LENS_W  = 16;

    // Register indexes other than the pattern registers.
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTHS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT = 3'd6;

    // Reset value of the pattern count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

    // Parity bit is cleared on every received byte.
    localparam logic [7:0] RX_MASK = 8'h7f;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_ERROR = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_WAITING = 3'd0,
        ST_MATCHED = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_ERROR   = 3'd3,
        ST_IDLE    = 3'd4
    } t_status;

    // Control handed from the sequencing logic to every window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

// File: hw/rtl/mpem_if.sv
// Stream channels of the multi-pattern expect matcher: input words and result words.
// Both carry valid, ready and the payload fields; no dependency on the package.
interface mpem_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mpem_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [1:0] match_index;

    modport source (output valid, output status, output match_index, input ready);
    modport sink   (input valid, input status, input match_index, output ready);
endinterface

// File: hw/rtl/mpem_cell.sv
// One cell of the history window: holds one byte and its fill bit, passes both on.
// Depends on mpem_pkg for the cell control struct.
module mpem_cell #(
    parameter int CELL_IDX = 0,
    parameter int NUM_PAT  = 4,
    parameter int MAX_LEN  = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mpem_pkg::t_cell_ctl     i_ctl,
    input  logic [7:0]              i_byte,
    input  logic                    i_valid,
    input  logic [8*MAX_LEN-1:0]    i_pat [NUM_PAT],
    input  logic [mpem_pkg::LEN_W-1:0] i_len [NUM_PAT],
    output logic [7:0]              o_byte,
    output logic                    o_valid,
    output logic [NUM_PAT-1:0]      o_ok
);

    localparam logic [mpem_pkg::LEN_W-1:0] POS = mpem_pkg::LEN_W'(CELL_IDX);

    logic [7:0] r_byte;
    logic       r_valid;
    logic       n_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_byte;
        end
    end

    // The compare looks at the byte this cell takes on the shift, so the
    // result reflects the window with the newest byte already in place.
    // Pattern byte len-1-pos lines up with this cell.
    always_comb begin
        logic [mpem_pkg::LEN_W-1:0] sel;
        logic [7:0]                 pb;
        for (int p = 0; p < NUM_PAT; p++) begin
            sel = i_len[p] - POS - mpem_pkg::LEN_W'(1);
            pb  = 8'h00;
            for (int k = 0; k < MAX_LEN; k++) begin
                if (sel == mpem_pkg::LEN_W'(k)) begin
                    pb = i_pat[p][8*k +: 8];
                end
            end
            o_ok[p] = (POS >= i_len[p]) || (i_valid && (i_byte == pb));
        end
    end

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

// File: hw/rtl/mpem_ctrl.sv
// Sequencing of the watch: start, tick countdown, link error, and the result register.
// Depends on mpem_pkg and the stream interfaces in mpem_if.sv.
module mpem_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    mpem_in_if.sink                      i_word,
    mpem_out_if.source                   o_result,
    input  logic [mpem_pkg::TICK_W-1:0]  i_timeout,
    input  logic                         i_hit,
    input  logic [1:0]                   i_hit_index,
    output mpem_pkg::t_cell_ctl          o_ctl
);

    logic                        r_watch;
    logic                        n_watch;
    logic [mpem_pkg::TICK_W-1:0] r_ticks;
    logic [mpem_pkg::TICK_W-1:0] n_ticks;
    logic                        r_ovalid;
    logic [2:0]                  r_status;
    logic [1:0]                  r_index;
    mpem_pkg::t_status           w_status;
    logic [1:0]                  w_index;
    logic                        w_accept;

    assign i_word.ready = !r_ovalid || o_result.ready;
    assign w_accept     = i_word.valid && i_word.ready;

    always_comb begin
        n_watch     = r_watch;
        n_ticks     = r_ticks;
        w_status    = mpem_pkg::ST_WAITING;
        w_index     = 2'd0;
        o_ctl.shift = 1'b0;
        o_ctl.clear = 1'b0;
        if (w_accept) begin
            if (mpem_pkg::t_opcode'(i_word.opcode) == mpem_pkg::OP_START) begin
                o_ctl.clear = 1'b1;
                n_ticks     = i_timeout;
                n_watch     = 1'b1;
            end else if (!r_watch) begin
                w_status = mpem_pkg::ST_IDLE;
            end else begin
                case (mpem_pkg::t_opcode'(i_word.opcode))
                    mpem_pkg::OP_BYTE: begin
                        o_ctl.shift = 1'b1;
                        if (i_hit) begin
                            w_status = mpem_pkg::ST_MATCHED;
                            w_index  = i_hit_index;
                            n_watch  = 1'b0;
                        end
                    end
                    mpem_pkg::OP_TICK: begin
                        // A count of zero or one both end the watch here.
                        if (r_ticks <= mpem_pkg::TICK_W'(1)) begin
                            n_ticks  = '0;
                            w_status = mpem_pkg::ST_TIMEOUT;
                            n_watch  = 1'b0;
                        end else begin
                            n_ticks = r_ticks - mpem_pkg::TICK_W'(1);
                        end
                    end
                    default: begin
                        w_status = mpem_pkg::ST_ERROR;
                        n_watch  = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_watch  <= 1'b0;
            r_ticks  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_watch <= n_watch;
            r_ticks <= n_ticks;
            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= w_status;
            r_index  <= w_index;
        end
    end

    assign o_result.valid       = r_ovalid;
    assign o_result.status      = r_status;
    assign o_result.match_index = r_index;

endmodule

// File: hw/rtl/multi_pattern_expect_matcher.sv
// Top level of the multi-pattern expect matcher: registers, window cell chain, match pick.
// Depends on mpem_pkg, mpem_if.sv, mpem_cell and mpem_ctrl.

// The matcher takes one word per clock cycle and returns exactly one result word
// for each, in the next cycle, through a result register; it keeps accepting while a
// result waits, as long as the result register is emptied in the same cycle. A start
// word opens a watch, clears the history window and loads the tick countdown from
// the timeout register; in a watch a received byte has its parity bit cleared and
// moves into a chain of MAX_PATTERN_LEN window cells, each holding one byte and a
// fill bit. Every cell compares the byte it is about to take against the matching
// byte of each pattern, and the per-cell results are ANDed and resolved lowest
// pattern first in the same cycle, so the byte compare, the AND across the chain
// and the priority pick all lie before the result register. A tick word counts down
// and reports a timeout at zero or one; a link error word ends the watch with error;
// outside a watch (after reset, match, timeout or error) every word but start reports
// idle. Registers written through the plain write port take effect on the next word.
module multi_pattern_expect_matcher #(
    parameter int PATTERN_SLOTS   = mpem_pkg::PATTERN_SLOTS_DEF,
    parameter int MAX_PATTERN_LEN = mpem_pkg::MAX_PATTERN_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [mpem_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [mpem_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    mpem_in_if.sink                          i_word,
    mpem_out_if.source                       o_result
);

    // No more pattern slots exist than the register map provides.
    localparam int NUM_PAT = (PATTERN_SLOTS < mpem_pkg::REG_PATTERNS) ?
                             PATTERN_SLOTS : mpem_pkg::REG_PATTERNS;
    localparam int PAT_W   = 8 * MAX_PATTERN_LEN;

    // Configuration registers. Pattern bytes beyond the window depth can never
    // take part in a match, so they are not stored.
    logic [PAT_W-1:0]             r_pat [NUM_PAT];
    logic [mpem_pkg::LENS_W-1:0]  r_lengths;
    logic [mpem_pkg::COUNT_W-1:0] r_count;
    logic [mpem_pkg::TICK_W-1:0]  r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAT; p++) begin
                r_pat[p] <= '0;
            end
            r_lengths <= '0;
            r_count   <= mpem_pkg::COUNT_RESET;
            r_timeout <= '0;
        end else if (i_cfg_we) begin
            for (int p = 0; p < NUM_PAT; p++) begin
                if (i_cfg_index == mpem_pkg::CFG_INDEX_W'(p)) begin
                    r_pat[p] <= i_cfg_wdata[PAT_W-1:0];
                end
            end
            if (i_cfg_index == mpem_pkg::REG_LENGTHS) begin
                r_lengths <= i_cfg_wdata[mpem_pkg::LENS_W-1:0];
            end
            if (i_cfg_index == mpem_pkg::REG_COUNT) begin
                r_count <= i_cfg_wdata[mpem_pkg::COUNT_W-1:0];
            end
            if (i_cfg_index == mpem_pkg::REG_TIMEOUT) begin
                r_timeout <= i_cfg_wdata[mpem_pkg::TICK_W-1:0];
            end
        end
    end

    logic [mpem_pkg::LEN_W-1:0] w_len [NUM_PAT];

    always_comb begin
        for (int p = 0; p < NUM_PAT; p++) begin
            w_len[p] = r_lengths[mpem_pkg::LEN_W*p +: mpem_pkg::LEN_W];
        end
    end

    // Window cell chain. Cell zero holds the newest byte and is fed with the
    // incoming byte; each further cell is fed by its neighbor.
    mpem_pkg::t_cell_ctl w_ctl;
    logic [7:0]          w_byte  [MAX_PATTERN_LEN+1];
    logic                w_valid [MAX_PATTERN_LEN+1];
    logic [NUM_PAT-1:0]  w_ok    [MAX_PATTERN_LEN];

    assign w_byte[0]  = i_word.rx_byte & mpem_pkg::RX_MASK;
    assign w_valid[0] = 1'b1;

    for (genvar c = 0; c < MAX_PATTERN_LEN; c++) begin : g_cell
        mpem_cell #(
            .CELL_IDX (c),
            .NUM_PAT  (NUM_PAT),
            .MAX_LEN  (MAX_PATTERN_LEN)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_byte  (w_byte[c]),
            .i_valid (w_valid[c]),
            .i_pat   (r_pat),
            .i_len   (w_len),
            .o_byte  (w_byte[c+1]),
            .o_valid (w_valid[c+1]),
            .o_ok    (w_ok[c])
        );
    end

    // A pattern matches when it is in use, its length fits the window, and
    // every cell agrees. The lowest matching index wins.
    logic       w_hit;
    logic [1:0] w_hit_index;

    always_comb begin
        logic all_ok;
        w_hit       = 1'b0;
        w_hit_index = 2'd0;
        for (int p = NUM_PAT - 1; p >= 0; p--) begin
            all_ok = 1'b1;
            for (int c = 0; c < MAX_PATTERN_LEN; c++) begin
                all_ok = all_ok & w_ok[c][p];
            end
            if (all_ok && (w_len[p] <= mpem_pkg::LEN_W'(MAX_PATTERN_LEN))
                    && ({1'b0, r_count} > (mpem_pkg::COUNT_W + 1)'(p))) begin
                w_hit       = 1'b1;
                w_hit_index = 2'(p);
            end
        end
    end

    mpem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_word      (i_word),
        .o_result    (o_result),
        .i_timeout   (r_timeout),
        .i_hit       (w_hit),
        .i_hit_index (w_hit_index),
        .o_ctl       (w_ctl)
    );

endmodule
